@@ hdl/mhpq_pkg.sv @@
// Package for the max-heap priority queue: sizes, item structs,
// status codes, controller states and the memory request struct.
// No dependencies; the controller, top level and testbench import it.
package mhpq_pkg;

    // Heap sizing
    localparam int CAPACITY = 128;
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 8;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Positions are one-based; children need one bit more than the count
    localparam int POS_W    = CNT_W + 1;

    localparam logic signed [VALUE_W-1:0] EMPTY_RESULT = -1;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                      cmd;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [1:0]                status;
        logic [ENTRY_W-1:0]        entry_count;
    } t_out_item;

    // One write and two reads per cycle
    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [VALUE_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr_a;
        logic [ADDR_W-1:0]  raddr_b;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_START,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

@@ hdl/mhpq_ram.sv @@
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
module mhpq_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ hdl/mhpq_ctrl.sv @@
// Heap controller: sift-up on insert, sift-down on remove, one level
// per read/compare pair against the heap RAM. Depends on mhpq_pkg.
module mhpq_ctrl import mhpq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  t_in_item            i_in_item,
    input  logic                i_out_free,
    input  logic [VALUE_W-1:0]  i_rdata_a,
    input  logic [VALUE_W-1:0]  i_rdata_b,
    output logic                o_busy,
    output logic                o_done_valid,
    output t_out_item           o_done_item,
    output t_mem_req            o_mem
);

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [POS_W-1:0]          r_idx, n_idx;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic signed [VALUE_W-1:0] r_res, n_res;
    logic [1:0]                r_status, n_status;

    logic                      w_accept;
    logic [POS_W-1:0]          w_count_pos;
    logic [POS_W-1:0]          w_par;
    logic [POS_W-1:0]          w_left;
    logic [POS_W-1:0]          w_right;
    logic signed [VALUE_W-1:0] w_rd_a;
    logic signed [VALUE_W-1:0] w_rd_b;
    logic                      w_full;
    logic                      w_up_move;
    logic                      w_left_in;
    logic                      w_pick_l;
    logic                      w_pick_r;
    logic signed [VALUE_W-1:0] w_big_val;
    logic                      w_dn_move;
    logic [POS_W-1:0]          w_child_pos;
    logic signed [VALUE_W-1:0] w_child_val;

    assign w_accept    = (r_state == S_IDLE) && i_in_valid;
    assign w_count_pos = POS_W'(r_count);
    assign w_par       = r_idx >> 1;
    assign w_left      = {r_idx[POS_W-2:0], 1'b0};
    assign w_right     = {r_idx[POS_W-2:0], 1'b1};
    assign w_rd_a      = $signed(i_rdata_a);
    assign w_rd_b      = $signed(i_rdata_b);
    assign w_full      = (w_count_pos >= POS_W'(CAPACITY));

    // Sift-up: parent on port a moves down when strictly smaller
    assign w_up_move   = (w_rd_a < r_val);

    // Sift-down: left child on port a, right on port b; left wins ties
    assign w_left_in   = (w_left <= w_count_pos);
    assign w_pick_l    = (r_val < w_rd_a);
    assign w_big_val   = w_pick_l ? w_rd_a : r_val;
    assign w_pick_r    = (w_right <= w_count_pos) && (w_big_val < w_rd_b);
    assign w_dn_move   = w_pick_l || w_pick_r;
    assign w_child_pos = w_pick_r ? w_right : w_left;
    assign w_child_val = w_pick_r ? w_rd_b : w_rd_a;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.cmd == CMD_INSERT) begin
                        n_state = w_full ? S_DONE : S_UP_RD;
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_DN_START;
                    end
                end
            end
            S_UP_RD:    n_state = (r_idx == POS_W'(1)) ? S_DONE : S_UP_CMP;
            S_UP_CMP:   n_state = w_up_move ? S_UP_RD : S_DONE;
            S_DN_START: n_state = S_DN_RD;
            S_DN_RD:    n_state = w_left_in ? S_DN_CMP : S_DONE;
            S_DN_CMP:   n_state = w_dn_move ? S_DN_RD : S_DONE;
            S_DONE:     n_state = i_out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_val       = r_val;
        n_res       = r_res;
        n_status    = r_status;
        o_mem.we    = 1'b0;
        o_mem.waddr = ADDR_W'(r_idx - POS_W'(1));
        o_mem.wdata = r_val;
        // Root and last entry are read while idle, ready for a remove
        o_mem.raddr_a = '0;
        o_mem.raddr_b = ADDR_W'(w_count_pos - POS_W'(1));
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res    = '0;
                    n_status = ST_DONE;
                    if (i_in_item.cmd == CMD_INSERT) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_idx   = w_count_pos + POS_W'(1);
                            n_val   = i_in_item.value;
                        end
                    end else if (r_count == '0) begin
                        n_res    = EMPTY_RESULT;
                        n_status = ST_EMPTY;
                    end
                end
            end
            S_UP_RD: begin
                if (r_idx == POS_W'(1)) begin
                    o_mem.we = 1'b1;
                end
                o_mem.raddr_a = ADDR_W'(w_par - POS_W'(1));
            end
            S_UP_CMP: begin
                o_mem.we = 1'b1;
                if (w_up_move) begin
                    o_mem.wdata = w_rd_a;
                    n_idx       = w_par;
                end
            end
            S_DN_START: begin
                n_res   = w_rd_a;
                n_val   = w_rd_b;
                n_count = r_count - CNT_W'(1);
                n_idx   = POS_W'(1);
            end
            S_DN_RD: begin
                o_mem.raddr_a = ADDR_W'(w_left - POS_W'(1));
                o_mem.raddr_b = ADDR_W'(w_right - POS_W'(1));
                if (!w_left_in) begin
                    o_mem.we = 1'b1;
                end
            end
            S_DN_CMP: begin
                o_mem.we = 1'b1;
                if (w_dn_move) begin
                    o_mem.wdata = w_child_val;
                    n_idx       = w_child_pos;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_res    <= n_res;
        r_status <= n_status;
    end

    assign o_busy                   = (r_state != S_IDLE);
    assign o_done_valid             = (r_state == S_DONE);
    assign o_done_item.result_value = r_res;
    assign o_done_item.status       = r_status;
    assign o_done_item.entry_count  = ENTRY_W'(r_count);

endmodule

@@ hdl/max_heap_priority_queue.sv @@
// Top level of the max-heap priority queue: controller, heap RAM and
// the result register. Depends on mhpq_pkg, mhpq_ram and mhpq_ctrl.
//
//  Channel  Direction  Handshake                  Item
//  in       input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
//  out      output     o_out_valid / i_out_stall  o_out_item (t_out_item)
//
// One item at a time. An empty remove or a full insert goes straight to
// the result; otherwise each heap level is one RAM read and one
// compare/write, as the heap RAM registers its read data. Reset clears
// the count and the controller; RAM contents are left as they are. A
// stalled result holds in the output register; the next item is accepted
// meanwhile and waits for it at the end.
module max_heap_priority_queue import mhpq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic               w_busy;
    logic               w_done_valid;
    t_out_item          w_done_item;
    t_mem_req           w_mem;
    logic [VALUE_W-1:0] w_rdata_a;
    logic [VALUE_W-1:0] w_rdata_b;
    logic               w_out_free;
    logic               w_load;
    logic               r_out_valid;
    t_out_item          r_out_item;

    mhpq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_out_free   (w_out_free),
        .i_rdata_a    (w_rdata_a),
        .i_rdata_b    (w_rdata_b),
        .o_busy       (w_busy),
        .o_done_valid (w_done_valid),
        .o_done_item  (w_done_item),
        .o_mem        (w_mem)
    );

    mhpq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_mem.we),
        .i_waddr   (w_mem.waddr),
        .i_wdata   (w_mem.wdata),
        .i_raddr_a (w_mem.raddr_a),
        .i_raddr_b (w_mem.raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Result register
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = w_done_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= w_done_item;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // A finished result lands in the output register unchanged
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && (o_out_item == $past(w_done_item))))
        else $error("result not moved into output register");

    // An empty remove reports -1
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_EMPTY))
            |-> (o_out_item.result_value == EMPTY_RESULT))
        else $error("empty remove without -1 result");

    // An accepted item keeps the input stalled on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting an item");
`endif

endmodule

@@ tb/max_heap_priority_queue_test.sv @@
`timescale 1ns / 1ps
// Testbench for max_heap_priority_queue: random and directed insert/remove items checked
// against a behavioral max-heap mirror. Depends on mhpq_pkg and the block's RTL only.
module max_heap_priority_queue_test;
    import mhpq_pkg::*;

    localparam int ITEM_TARGET    = 1750;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Heap mirror and run bookkeeping
    logic signed [VALUE_W-1:0] heap_mirror [1:CAPACITY];
    int        mirror_count = 0;
    t_in_item  pending_items[$];
    t_out_item heap_expect[$];
    logic      in_taken     = 1'b0;
    int        items_taken  = 0;
    int        errors       = 0;
    int        inserts_done = 0;
    int        removes_done = 0;
    int        empty_hits   = 0;
    int        full_hits    = 0;
    int        peak_count   = 0;

    max_heap_priority_queue DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one operation to the mirror and return the result it should produce
    function automatic t_out_item heap_apply(input t_in_item it);
        t_out_item                 res;
        int                        idx;
        int                        par;
        int                        lft;
        int                        big;
        logic signed [VALUE_W-1:0] tmp;
        logic                      settled;
        res.result_value = '0;
        res.status       = ST_DONE;
        if (it.cmd == CMD_INSERT) begin
            inserts_done++;
            if (mirror_count >= CAPACITY) begin
                res.status = ST_FULL;
                full_hits++;
            end else begin
                mirror_count++;
                idx = mirror_count;
                heap_mirror[idx] = it.value;
                settled = 1'b0;
                // sift up while the parent is strictly smaller
                while (idx > 1 && !settled) begin
                    par = idx / 2;
                    if (heap_mirror[par] < heap_mirror[idx]) begin
                        tmp              = heap_mirror[par];
                        heap_mirror[par] = heap_mirror[idx];
                        heap_mirror[idx] = tmp;
                        idx              = par;
                    end else begin
                        settled = 1'b1;
                    end
                end
            end
        end else begin
            removes_done++;
            if (mirror_count == 0) begin
                res.result_value = EMPTY_RESULT;
                res.status       = ST_EMPTY;
                empty_hits++;
            end else begin
                res.result_value = heap_mirror[1];
                heap_mirror[1]   = heap_mirror[mirror_count];
                mirror_count--;
                idx     = 1;
                settled = 1'b0;
                // sift down toward the larger child, left wins ties
                while (idx < mirror_count && !settled) begin
                    lft = 2 * idx;
                    big = idx;
                    if (lft <= mirror_count && heap_mirror[big] < heap_mirror[lft])
                        big = lft;
                    if (lft + 1 <= mirror_count && heap_mirror[big] < heap_mirror[lft + 1])
                        big = lft + 1;
                    if (big == idx) begin
                        settled = 1'b1;
                    end else begin
                        tmp              = heap_mirror[big];
                        heap_mirror[big] = heap_mirror[idx];
                        heap_mirror[idx] = tmp;
                        idx              = big;
                    end
                end
            end
        end
        if (mirror_count > peak_count)
            peak_count = mirror_count;
        res.entry_count = ENTRY_W'(mirror_count);
        return res;
    endfunction

    // Mix of wide random values, small values that collide, and extremes
    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            5, 6:    v = $signed($urandom_range(0, 15)) - 8;
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7fffffff;
                    1:       v = 32'sh80000000;
                    2:       v = 32'sh0;
                    default: v = -32'sd1;
                endcase
            end
            8:       v = 32'sh7fffff00 + $urandom_range(0, 255);
            9:       v = 32'sh80000000 + $urandom_range(0, 255);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void queue_item(input t_cmd c, input logic signed [VALUE_W-1:0] v);
        t_in_item it;
        it.cmd   = c;
        it.value = v;
        pending_items.push_back(it);
    endfunction

    // Stimulus, reset and end of run
    initial begin
        int k;
        int seg_len;
        int insert_pct;

        // directed: empty remove, extremes, ties, drain past empty
        queue_item(CMD_REMOVE, 32'sh12345678);
        queue_item(CMD_INSERT, 32'sh7fffffff);
        queue_item(CMD_INSERT, 32'sh80000000);
        queue_item(CMD_INSERT, 32'sh0);
        queue_item(CMD_INSERT, -32'sd1);
        queue_item(CMD_INSERT, 32'sd5);
        queue_item(CMD_INSERT, 32'sd5);
        queue_item(CMD_INSERT, 32'sd5);
        queue_item(CMD_INSERT, 32'sh80000000);
        queue_item(CMD_INSERT, 32'sd1);
        queue_item(CMD_REMOVE, -32'sd1);
        queue_item(CMD_INSERT, 32'sd2);
        for (k = 0; k < 10; k++)
            queue_item(CMD_REMOVE, 32'sh0);
        queue_item(CMD_REMOVE, 32'sh7fffffff);

        // fill past capacity, then drain past empty
        for (k = 0; k < CAPACITY + 8; k++)
            queue_item(CMD_INSERT, rand_value());
        for (k = 0; k < CAPACITY + 4; k++)
            queue_item(CMD_REMOVE, rand_value());

        // random segments biased toward filling, draining or balance
        while (pending_items.size() < ITEM_TARGET) begin
            seg_len = $urandom_range(20, 150);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            for (k = 0; k < seg_len; k++)
                queue_item(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                           rand_value());
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (heap_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d inserts (%0d dropped full), %0d removes (%0d empty).",
                 items_taken, inserts_done, full_hits, removes_done, empty_hits);
        $display("Peak occupancy %0d of %0d entries, %0d mismatches.",
                 peak_count, CAPACITY, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Driver: bursts of items with random gaps, payload held while stalled
    always @(negedge i_clk) begin
        static int burst_left = 1;
        static int gap_left   = 0;
        logic      valid_next;
        t_in_item  item_next;
        valid_next = i_in_valid;
        item_next  = i_in_item;
        if (i_rst_n && !(i_in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                valid_next = 1'b0;
                gap_left--;
            end else if (pending_items.size() != 0) begin
                valid_next = 1'b1;
                item_next  = pending_items.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                valid_next = 1'b0;
            end
        end
        i_in_valid <= valid_next;
        i_in_item  <= item_next;
    end

    // Receiver: stall patterns that change over time, plus two long hold-offs
    always @(negedge i_clk) begin
        static t_stall_mode mode      = STALL_NONE;
        static int          mode_left = 0;
        static int          period    = 2;
        static int          phase     = 0;
        static int          hold_left = 0;
        static logic        hold_a    = 1'b0;
        static logic        hold_b    = 1'b0;
        logic               stall_next;
        if (!hold_a && items_taken >= 100) begin
            hold_a    = 1'b1;
            hold_left = HOLD_CYCLES;
        end else if (!hold_b && items_taken >= 1200) begin
            hold_b    = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            mode      = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 160);
            period    = $urandom_range(2, 9);
            phase     = 0;
        end
        mode_left--;
        phase++;
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else begin
            case (mode)
                STALL_LIGHT:    stall_next = ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    stall_next = ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: stall_next = ((phase % period) < (period / 2));
                default:        stall_next = 1'b0;
            endcase
        end
        i_out_stall <= stall_next;
    end

    // Monitor: check results, then record newly accepted items
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (heap_expect.size() == 0) begin
                    $error("result with nothing expected: value %0d status %0d count %0d",
                           o_out_item.result_value, o_out_item.status,
                           o_out_item.entry_count);
                    errors++;
                end else begin
                    want = heap_expect.pop_front();
                    if (o_out_item.result_value !== want.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               want.result_value, o_out_item.result_value);
                        errors++;
                    end
                    if (o_out_item.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                        errors++;
                    end
                    if (o_out_item.entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, o_out_item.entry_count);
                        errors++;
                    end
                end
            end
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                heap_expect.push_back(heap_apply(i_in_item));
                items_taken++;
            end
        end
    end

    // Watchdog: too long without any accepted item on either side
    always @(posedge i_clk) begin
        static int idle_cycles = 0;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                     idle_cycles, heap_expect.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
